@@ design/ddo_pkg.sv @@
// Shared types, constants and tables for the differential drive odometry core.
`default_nettype none
package ddo_pkg;

  // Default values for the top level parameters.
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  // Operand widths of the shared multiplier.
  localparam int MUL_AW = 64;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Angle constants in degrees, Q16.16.
  localparam logic signed [27:0] DEG360 = 28'sd23592960;
  localparam logic signed [27:0] DEG180 = 28'sd11796480;
  localparam logic signed [27:0] DEG90  = 28'sd5898240;

  // CORDIC start vector, prescaled by the inverse gain, Q2.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

  // 2*pi in Q16.16 and the radian to degree factor in Q16.16.
  localparam logic [33:0] TWO_PI_Q16     = 34'd411775;
  localparam logic signed [33:0] RAD_TO_DEG = 34'sd3754936;

  // Products are clamped to this magnitude before they reach an adder.
  localparam logic [63:0] LIM62 = 64'h2000_0000_0000_0000;

  // Product shift amounts.
  localparam logic [4:0] SH_NONE = 5'd0;
  localparam logic [4:0] SH_DEG  = 5'd16;
  localparam logic [4:0] SH_Q30  = 5'd30;
  localparam logic [4:0] SH_Q31  = 5'd31;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_EFF_WIDTH  = 3'd0,
    REG_BODY_LEN   = 3'd1,
    REG_BODY_WID   = 3'd2,
    REG_EPSILON    = 3'd3,
    REG_START_X    = 3'd4,
    REG_START_Y    = 3'd5,
    REG_START_HDG  = 3'd6
  } cfg_idx_t;

  // Shared multiplier request and response.
  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
    logic [4:0]               sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               neg;
    logic [63:0]        mag;
    logic signed [63:0] res;
  } mul_rsp_t;

  // Shared divider request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [33:0] rem;
  } div_rsp_t;

  // CORDIC request and response.
  typedef struct packed {
    logic               start;
    logic signed [26:0] ang;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] c;
    logic signed [33:0] s;
  } cor_rsp_t;

  // Arctangent of 2^-i in degrees, Q16.16.
  function automatic logic [22:0] atan_deg(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // Saturate a 33-bit difference to 32 signed bits.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/differential_drive_odometry_core.sv @@
// Top level of the differential drive odometry core: sequencer and pose state.
//
//  Channel | Direction | Handshake          | Word
//  in_     | input     | in_valid/in_stall  | restart, left/right position, heading
//  out_    | output    | out_valid/out_stall| pose and four chassis corners
//  cfg_    | input     | cfg_valid/cfg_ready| register index and data
//
// One word at a time. The time is set by the bit-serial multiplier, the restoring
// divider and the CORDIC: a restart uses the fewest passes through them, straight
// motion more and an arc the most.
// in_stall is high from acceptance until the result word is taken; the result holds
// while out_stall is high. Reset is synchronous and loads the register defaults and a
// zero pose; configuration is always ready.
`default_nettype none
module differential_drive_odometry_core
  import ddo_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_restart,
  input  wire logic signed [31:0] in_left_position,
  input  wire logic signed [31:0] in_right_position,
  input  wire logic signed [25:0] in_heading_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_pose_x,
  output logic signed [31:0]      out_pose_y,
  output logic signed [25:0]      out_pose_heading,
  output logic signed [31:0]      out_front_left_x,
  output logic signed [31:0]      out_front_left_y,
  output logic signed [31:0]      out_front_right_x,
  output logic signed [31:0]      out_front_right_y,
  output logic signed [31:0]      out_back_left_x,
  output logic signed [31:0]      out_back_left_y,
  output logic signed [31:0]      out_back_right_x,
  output logic signed [31:0]      out_back_right_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam logic signed [63:0] CW_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] CW_MIN = -CW_MAX - 64'sd1;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_TRIG_H = 20'h00002,
    ST_MUL_SX = 20'h00004,
    ST_MUL_SY = 20'h00008,
    ST_MUL_RN = 20'h00010,
    ST_DIV_R  = 20'h00020,
    ST_DIV_W  = 20'h00040,
    ST_DIV_M  = 20'h00080,
    ST_MUL_WD = 20'h00100,
    ST_TRIG_W = 20'h00200,
    ST_MUL_AX = 20'h00400,
    ST_MUL_AY = 20'h00800,
    ST_TRIG_F = 20'h01000,
    ST_MUL_LC = 20'h02000,
    ST_MUL_LS = 20'h04000,
    ST_MUL_WC = 20'h08000,
    ST_MUL_WS = 20'h10000,
    ST_CORN_A = 20'h20000,
    ST_CORN_B = 20'h40000,
    ST_OUT    = 20'h80000
  } state_t;

  // Saturate to the coordinate width.
  function automatic logic signed [COORD_WIDTH-1:0] sat_cw(input logic signed [63:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    if (v > CW_MAX) begin
      r = CW_MAX[COORD_WIDTH-1:0];
    end else if (v < CW_MIN) begin
      r = CW_MIN[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // Low 32 bits of a coordinate, sign extended first.
  function automatic logic [31:0] low32(input logic signed [COORD_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  state_t state_r, state_nxt;
  logic   started_r;

  // Configuration registers.
  logic [30:0]        eff_width_r, body_len_r, body_wid_r;
  logic [15:0]        eps_r;
  logic signed [31:0] start_x_r, start_y_r;
  logic signed [25:0] start_hd_r;

  // Pose state.
  logic signed [31:0]            prev_l_r, prev_r_r;
  logic signed [COORD_WIDTH-1:0] cx_r, cy_r;
  logic signed [25:0]            ch_r;

  // Working registers.
  logic signed [31:0] lp_r, rp_r, dl_r, dr_r;
  logic signed [25:0] h_r;
  logic signed [33:0] c0_r, s0_r, c1_r, s1_r;
  logic [63:0]        num_mag_r, wq_r;
  logic               num_neg_r;
  logic signed [63:0] rad_r;
  logic [18:0]        wr_r;
  logic signed [26:0] wdeg_r;
  logic signed [33:0] lc_r, ls_r, wc_r, ws_r;
  logic signed [35:0] ca_r, cb_r, cc_r, cd_r;
  logic [31:0]        fl_x_r, fl_y_r, fr_x_r, fr_y_r, bl_x_r, bl_y_r, br_x_r, br_y_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;
  cor_req_t creq;
  cor_rsp_t crsp;

  logic               in_acc;
  logic               out_acc;
  logic signed [32:0] diff_w, sum_w;
  logic               diff_neg_w;
  logic [32:0]        diff_mag_w;
  logic               straight_w;
  logic [30:0]        wdt_w;
  logic               op_done_w;
  logic               is_mul_w, is_div_w, is_cor_w;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Wheel delta arithmetic.
  assign diff_w     = 33'(dr_r) - 33'(dl_r);
  assign sum_w      = 33'(dl_r) + 33'(dr_r);
  assign diff_neg_w = diff_w[32];
  assign diff_mag_w = diff_neg_w ? (~diff_w + 33'd1) : diff_w;
  assign straight_w = (diff_w == 33'sd0) || (diff_mag_w < 33'(eps_r));
  assign wdt_w      = (eff_width_r == '0) ? 31'd1 : eff_width_r;

  // Which shared unit the current state uses.
  assign is_mul_w = state_r inside {ST_MUL_SX, ST_MUL_SY, ST_MUL_RN, ST_MUL_WD, ST_MUL_AX,
                                    ST_MUL_AY, ST_MUL_LC, ST_MUL_LS, ST_MUL_WC, ST_MUL_WS};
  assign is_div_w = state_r inside {ST_DIV_R, ST_DIV_W, ST_DIV_M};
  assign is_cor_w = state_r inside {ST_TRIG_H, ST_TRIG_W, ST_TRIG_F};
  assign op_done_w = (is_mul_w && mrsp.done) || (is_div_w && drsp.done) ||
                     (is_cor_w && crsp.done);

  // Multiplier operands.
  always_comb begin
    mreq = '0;
    case (state_r)
      ST_MUL_SX: begin mreq.a = 64'(dr_r); mreq.b = c0_r; mreq.sh = SH_Q30; end
      ST_MUL_SY: begin mreq.a = 64'(dr_r); mreq.b = s0_r; mreq.sh = SH_Q30; end
      ST_MUL_RN: begin
        mreq.a  = $signed({33'd0, wdt_w});
        mreq.b  = 34'(sum_w);
        mreq.sh = SH_NONE;
      end
      ST_MUL_WD: begin
        mreq.a  = $signed({45'd0, wr_r});
        mreq.b  = RAD_TO_DEG;
        mreq.sh = SH_DEG;
      end
      ST_MUL_AX: begin mreq.a = rad_r; mreq.b = s1_r - s0_r; mreq.sh = SH_Q30; end
      ST_MUL_AY: begin mreq.a = rad_r; mreq.b = c0_r - c1_r; mreq.sh = SH_Q30; end
      ST_MUL_LC: begin mreq.a = $signed({33'd0, body_len_r}); mreq.b = c1_r; mreq.sh = SH_Q31; end
      ST_MUL_LS: begin mreq.a = $signed({33'd0, body_len_r}); mreq.b = s1_r; mreq.sh = SH_Q31; end
      ST_MUL_WC: begin mreq.a = $signed({33'd0, body_wid_r}); mreq.b = c1_r; mreq.sh = SH_Q31; end
      ST_MUL_WS: begin mreq.a = $signed({33'd0, body_wid_r}); mreq.b = s1_r; mreq.sh = SH_Q31; end
      default: ;
    endcase
    mreq.start = is_mul_w && !started_r;
  end

  // Divider operands.
  always_comb begin
    dreq = '0;
    case (state_r)
      ST_DIV_R: begin dreq.num = num_mag_r; dreq.den = {diff_mag_w, 1'b0}; end
      ST_DIV_W: begin dreq.num = {15'd0, diff_mag_w, 16'd0}; dreq.den = {3'd0, wdt_w}; end
      ST_DIV_M: begin dreq.num = wq_r; dreq.den = TWO_PI_Q16; end
      default: ;
    endcase
    dreq.start = is_div_w && !started_r;
  end

  // CORDIC angle.
  always_comb begin
    creq = '0;
    case (state_r)
      ST_TRIG_H: creq.ang = 27'(h_r);
      ST_TRIG_W: creq.ang = 27'(h_r) + wdeg_r;
      ST_TRIG_F: creq.ang = 27'(ch_r);
      default: ;
    endcase
    creq.start = is_cor_w && !started_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = in_restart ? ST_TRIG_F : ST_TRIG_H;
      end
      ST_TRIG_H: if (op_done_w) state_nxt = straight_w ? ST_MUL_SX : ST_MUL_RN;
      ST_MUL_SX: if (op_done_w) state_nxt = ST_MUL_SY;
      ST_MUL_SY: if (op_done_w) state_nxt = ST_TRIG_F;
      ST_MUL_RN: if (op_done_w) state_nxt = ST_DIV_R;
      ST_DIV_R:  if (op_done_w) state_nxt = ST_DIV_W;
      ST_DIV_W:  if (op_done_w) state_nxt = ST_DIV_M;
      ST_DIV_M:  if (op_done_w) state_nxt = ST_MUL_WD;
      ST_MUL_WD: if (op_done_w) state_nxt = ST_TRIG_W;
      ST_TRIG_W: if (op_done_w) state_nxt = ST_MUL_AX;
      ST_MUL_AX: if (op_done_w) state_nxt = ST_MUL_AY;
      ST_MUL_AY: if (op_done_w) state_nxt = ST_TRIG_F;
      ST_TRIG_F: if (op_done_w) state_nxt = ST_MUL_LC;
      ST_MUL_LC: if (op_done_w) state_nxt = ST_MUL_LS;
      ST_MUL_LS: if (op_done_w) state_nxt = ST_MUL_WC;
      ST_MUL_WC: if (op_done_w) state_nxt = ST_MUL_WS;
      ST_MUL_WS: if (op_done_w) state_nxt = ST_CORN_A;
      ST_CORN_A: state_nxt = ST_CORN_B;
      ST_CORN_B: state_nxt = ST_OUT;
      ST_OUT:    if (out_acc) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and pose state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      eff_width_r <= 31'd65536;
      body_len_r  <= '0;
      body_wid_r  <= '0;
      eps_r       <= 16'd1;
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_hd_r  <= '0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      ch_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (op_done_w) begin
        started_r <= 1'b0;
      end else if (is_mul_w || is_div_w || is_cor_w) begin
        started_r <= 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EFF_WIDTH: eff_width_r <= cfg_data[30:0];
          REG_BODY_LEN:  body_len_r  <= cfg_data[30:0];
          REG_BODY_WID:  body_wid_r  <= cfg_data[30:0];
          REG_EPSILON:   eps_r       <= cfg_data[15:0];
          REG_START_X:   start_x_r   <= cfg_data;
          REG_START_Y:   start_y_r   <= cfg_data;
          REG_START_HDG: start_hd_r  <= cfg_data[25:0];
          default: ;
        endcase
      end

      // Restart loads the start pose; motion updates x, then y together with heading.
      if (in_acc && in_restart) begin
        cx_r     <= sat_cw(64'(start_x_r));
        cy_r     <= sat_cw(64'(start_y_r));
        ch_r     <= start_hd_r;
        prev_l_r <= '0;
        prev_r_r <= '0;
      end
      if (mrsp.done) begin
        case (state_r)
          ST_MUL_SX, ST_MUL_AX: cx_r <= sat_cw(64'(cx_r) + mrsp.res);
          ST_MUL_SY, ST_MUL_AY: begin
            cy_r     <= sat_cw(64'(cy_r) + mrsp.res);
            ch_r     <= h_r;
            prev_l_r <= lp_r;
            prev_r_r <= rp_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_acc && !in_restart) begin
      lp_r <= in_left_position;
      rp_r <= in_right_position;
      h_r  <= in_heading_in;
      dl_r <= sat32(33'(in_left_position) - 33'(prev_l_r));
      dr_r <= sat32(33'(in_right_position) - 33'(prev_r_r));
    end
    if (crsp.done && (state_r == ST_TRIG_H)) begin
      c0_r <= crsp.c;
      s0_r <= crsp.s;
    end
    if (crsp.done && ((state_r == ST_TRIG_W) || (state_r == ST_TRIG_F))) begin
      c1_r <= crsp.c;
      s1_r <= crsp.s;
    end
    if (drsp.done) begin
      case (state_r)
        ST_DIV_R: rad_r <= (num_neg_r ^ diff_neg_w) ? -$signed(drsp.quo) : $signed(drsp.quo);
        ST_DIV_W: wq_r  <= drsp.quo;
        ST_DIV_M: wr_r  <= drsp.rem[18:0];
        default: ;
      endcase
    end
    if (mrsp.done) begin
      case (state_r)
        ST_MUL_RN: begin
          num_mag_r <= mrsp.mag;
          num_neg_r <= mrsp.neg;
        end
        ST_MUL_WD: wdeg_r <= diff_neg_w ? -27'(mrsp.res) : 27'(mrsp.res);
        ST_MUL_LC: lc_r <= 34'(mrsp.res);
        ST_MUL_LS: ls_r <= 34'(mrsp.res);
        ST_MUL_WC: wc_r <= 34'(mrsp.res);
        ST_MUL_WS: ws_r <= 34'(mrsp.res);
        default: ;
      endcase
    end
    // Rotated corner offsets, then the saturated corners.
    if (state_r == ST_CORN_A) begin
      ca_r <= 36'(lc_r) - 36'(ws_r);
      cb_r <= 36'(lc_r) + 36'(ws_r);
      cc_r <= 36'(ls_r) + 36'(wc_r);
      cd_r <= 36'(ls_r) - 36'(wc_r);
    end
    if (state_r == ST_CORN_B) begin
      fl_x_r <= low32(sat_cw(64'(cx_r) + 64'(ca_r)));
      fl_y_r <= low32(sat_cw(64'(cy_r) + 64'(cc_r)));
      fr_x_r <= low32(sat_cw(64'(cx_r) + 64'(cb_r)));
      fr_y_r <= low32(sat_cw(64'(cy_r) + 64'(cd_r)));
      bl_x_r <= low32(sat_cw(64'(cx_r) - 64'(cb_r)));
      bl_y_r <= low32(sat_cw(64'(cy_r) - 64'(cd_r)));
      br_x_r <= low32(sat_cw(64'(cx_r) - 64'(ca_r)));
      br_y_r <= low32(sat_cw(64'(cy_r) - 64'(cc_r)));
    end
  end

  // Shared units.
  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  // Result word.
  assign out_pose_x        = low32(cx_r);
  assign out_pose_y        = low32(cy_r);
  assign out_pose_heading  = ch_r;
  assign out_front_left_x  = fl_x_r;
  assign out_front_left_y  = fl_y_r;
  assign out_front_right_x = fr_x_r;
  assign out_front_right_y = fr_y_r;
  assign out_back_left_x   = bl_x_r;
  assign out_back_left_y   = bl_y_r;
  assign out_back_right_x  = br_x_r;
  assign out_back_right_y  = br_y_r;

  // The input side is closed whenever a result word is offered.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result offered while input open");

  // A taken result reopens the input on the next cycle.
  a_out_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> !in_stall) else $error("input not reopened after result");

  // The multiplier and divider never finish together.
  a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mrsp.done && drsp.done)) else $error("two shared units finished at once");

  // A restart word loads the start heading.
  a_restart_hdg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_restart) |=> (ch_r == $past(start_hd_r)))
    else $error("restart did not load start heading");

endmodule
`default_nettype wire

@@ design/ddo_mul.sv @@
// Bit-serial shift-add multiplier with shift, clamp and sign fix-up.
`default_nettype none
module ddo_mul
  import ddo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam int CW = $clog2(MUL_BW);

  logic              busy_r;
  logic              post_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [MUL_AW-1:0] a_mag_r;
  logic [MUL_PW-1:0] acc_r;
  logic              neg_r;
  logic [4:0]        sh_r;
  logic [63:0]       mag_r;
  logic signed [63:0] res_r;

  logic [MUL_AW-1:0] a_mag_w;
  logic [MUL_BW-1:0] b_mag_w;
  logic [MUL_AW:0]   upper_w;
  logic [MUL_PW-1:0] shifted_w;
  logic [63:0]       clamp_w;

  // Operand magnitudes at the start of a product.
  assign a_mag_w = req.a[MUL_AW-1] ? (~req.a + MUL_AW'(1)) : req.a;
  assign b_mag_w = req.b[MUL_BW-1] ? (~req.b + MUL_BW'(1)) : req.b;

  // One partial product per cycle is added to the upper half.
  assign upper_w = acc_r[0] ? ({1'b0, acc_r[MUL_PW-1:MUL_BW]} + {1'b0, a_mag_r})
                            : {1'b0, acc_r[MUL_PW-1:MUL_BW]};

  // Scale and clamp the finished magnitude.
  assign shifted_w = acc_r >> sh_r;
  assign clamp_w   = (shifted_w > MUL_PW'(LIM62)) ? LIM62 : shifted_w[63:0];

  // Sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      post_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r == CW'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
          post_r <= 1'b1;
        end
      end else if (post_r) begin
        post_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_mag_r <= a_mag_w;
      acc_r   <= {{MUL_AW{1'b0}}, b_mag_w};
      neg_r   <= req.a[MUL_AW-1] ^ req.b[MUL_BW-1];
      sh_r    <= req.sh;
      cnt_r   <= '0;
    end else if (busy_r) begin
      acc_r <= {upper_w, acc_r[MUL_BW-1:1]};
      cnt_r <= cnt_r + CW'(1);
    end else if (post_r) begin
      mag_r <= acc_r[63:0];
      res_r <= neg_r ? -$signed(clamp_w) : $signed(clamp_w);
    end
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.mag  = mag_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

@@ design/ddo_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ddo_div
  import ddo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [33:0] rem_r;
  logic [33:0] den_r;

  logic [34:0] trial_w;
  logic [34:0] diff_w;
  logic        fit_w;

  // Shift in the next dividend bit and try the subtraction.
  assign trial_w = {rem_r, quo_r[63]};
  assign diff_w  = trial_w - {1'b0, den_r};
  assign fit_w   = trial_w >= {1'b0, den_r};

  // Sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 6'd63)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fit_w ? diff_w[33:0] : trial_w[33:0];
      quo_r <= {quo_r[62:0], fit_w};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

@@ design/ddo_cordic.sv @@
// Iterative CORDIC for cosine and sine of an angle in degrees.
`default_nettype none
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cor_req_t req,
  output cor_rsp_t      rsp
);

  localparam int ITW = $clog2(STEPS);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RED  = 4'b0010,
    C_FOLD = 4'b0100,
    C_ITER = 4'b1000
  } cst_t;

  cst_t               cst_r, cst_nxt;
  logic               done_r;
  logic signed [27:0] a_r;
  logic signed [33:0] x_r, y_r;
  logic [ITW-1:0]     i_r;
  logic               flip_r;
  logic signed [33:0] c_r, s_r;

  logic signed [27:0] a_wrap_w, a_fold_w, at_w, a_new_w;
  logic               flip_w;
  logic signed [33:0] x_new_w, y_new_w;
  logic               last_w;

  // Wrap into one half turn each way, then fold into the right half plane.
  always_comb begin
    if (a_r >= DEG180) begin
      a_wrap_w = a_r - DEG360;
    end else if (a_r < -DEG180) begin
      a_wrap_w = a_r + DEG360;
    end else begin
      a_wrap_w = a_r;
    end
    flip_w = 1'b0;
    if (a_wrap_w > DEG90) begin
      a_fold_w = a_wrap_w - DEG180;
      flip_w   = 1'b1;
    end else if (a_wrap_w < -DEG90) begin
      a_fold_w = a_wrap_w + DEG180;
      flip_w   = 1'b1;
    end else begin
      a_fold_w = a_wrap_w;
    end
  end

  // One micro-rotation.
  assign at_w = 28'(atan_deg(5'(i_r)));
  always_comb begin
    if (!a_r[27]) begin
      x_new_w = x_r - (y_r >>> i_r);
      y_new_w = y_r + (x_r >>> i_r);
      a_new_w = a_r - at_w;
    end else begin
      x_new_w = x_r + (y_r >>> i_r);
      y_new_w = y_r - (x_r >>> i_r);
      a_new_w = a_r + at_w;
    end
  end
  assign last_w = (i_r == ITW'(STEPS - 1));

  // Next state.
  always_comb begin
    cst_nxt = cst_r;
    case (cst_r)
      C_IDLE: if (req.start) cst_nxt = C_RED;
      C_RED: begin
        if ((a_r < DEG360) && (a_r > -DEG360)) cst_nxt = C_FOLD;
      end
      C_FOLD: cst_nxt = C_ITER;
      C_ITER: if (last_w) cst_nxt = C_IDLE;
      default: cst_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      cst_r  <= cst_nxt;
      done_r <= (cst_r == C_ITER) && last_w;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (cst_r)
      C_IDLE: if (req.start) a_r <= 28'(req.ang);
      C_RED: begin
        if (a_r >= DEG360) begin
          a_r <= a_r - DEG360;
        end else if (a_r <= -DEG360) begin
          a_r <= a_r + DEG360;
        end
      end
      C_FOLD: begin
        a_r    <= a_fold_w;
        flip_r <= flip_w;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        i_r    <= '0;
      end
      C_ITER: begin
        x_r <= x_new_w;
        y_r <= y_new_w;
        a_r <= a_new_w;
        i_r <= i_r + ITW'(1);
        if (last_w) begin
          c_r <= flip_r ? -x_new_w : x_new_w;
          s_r <= flip_r ? -y_new_w : y_new_w;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.c    = c_r;
  assign rsp.s    = s_r;

endmodule
`default_nettype wire
